### rtl/core/assert_macros.svh
// Assertion macros used by the radial deadzone core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion, checked during reset as well.
`define ASD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/core/asd_pkg.sv
// Package for the analog stick radial deadzone core: types, widths and register codes.
package asd_pkg;

    localparam int unsigned AXIS_W     = 16;
    localparam int unsigned DZ_W       = 16;
    localparam int unsigned RS_W       = 9;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [RS_W-1:0] RS_MIN   = 9'd128;
    localparam logic [RS_W-1:0] RS_MAX   = 9'd384;
    localparam logic [RS_W-1:0] RS_RESET = 9'd256;
    localparam logic [DZ_W-1:0] DZ_RESET = 16'd0;

    localparam int unsigned FULL_SCALE_COUNTS_DEF = 100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEAD_ZONE   = 1'b0,
        CFG_RANGE_SCALE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x_raw;
        logic signed [AXIS_W-1:0] y_raw;
    } t_in;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x_out;
        logic signed [AXIS_W-1:0] y_out;
    } t_out;

endpackage

### rtl/core/analog_stick_radial_deadzone_core.sv
// Throughput one request per cycle while the output side is not stalled.
// Depth is set by the 32-stage square root and the 17, 17 and 16-stage restoring dividers.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits, dead_zone to 0 and range_scale
// to 256; derived divisors follow the range through r_d then r_dd, and the deadzone through r_dv.
module analog_stick_radial_deadzone_core #(
    parameter int unsigned FULL_SCALE_COUNTS = asd_pkg::FULL_SCALE_COUNTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  asd_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output asd_pkg::t_out                    o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [asd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [asd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import asd_pkg::*;

    localparam int unsigned D_MAX    = FULL_SCALE_COUNTS * int'(RS_MAX);
    localparam int unsigned D_W      = $clog2(D_MAX + 1);
    localparam int unsigned DD_W     = 2 * D_W;
    localparam int unsigned CMP_W    = (DD_W > 48) ? DD_W : 48;
    localparam int unsigned MAG_W    = AXIS_W;
    localparam int unsigned SQ_W     = 2 * MAG_W;
    localparam int unsigned ROOT_W   = 32;
    localparam int unsigned REM_W    = ROOT_W + 2;
    localparam int unsigned SQ_STEPS = ROOT_W;
    localparam int unsigned Q_W      = 17;
    localparam int unsigned R_STEPS  = Q_W;
    localparam int unsigned G_STEPS  = Q_W;
    localparam int unsigned A_STEPS  = AXIS_W;
    localparam int unsigned P_W      = Q_W + MAG_W;
    localparam int unsigned AR_W     = ROOT_W + 1;
    localparam int unsigned PIPE_LEN = 3 + (SQ_STEPS + 1) + (R_STEPS + 1) + 1
                                       + (G_STEPS + 1) + 1 + (A_STEPS + 1) + 1;
    localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [AXIS_W-1:0] POS_MAX = 16'h7fff;
    localparam logic [AXIS_W-1:0] NEG_MAX = 16'h8000;

    typedef struct packed {
        logic [MAG_W-1:0]  mx;
        logic [MAG_W-1:0]  my;
        logic              nx;
        logic              ny;
        logic              kill;
        logic              clamp;
        logic [ROOT_W-1:0] s8;
    } t_sb;

    logic en;
    logic [PIPE_LEN-1:0] r_vld;

    logic [DZ_W-1:0] r_dz;
    logic [RS_W-1:0] r_rs;
    logic [RS_W-1:0] n_rc;
    logic [D_W-1:0]  r_d;
    logic [DD_W-1:0] r_dd;
    logic [Q_W-1:0]  r_dv;

    assign en          = !r_vld[PIPE_LEN-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_vld[PIPE_LEN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz <= DZ_RESET;
            r_rs <= RS_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEAD_ZONE:   r_dz <= i_cfg_data[DZ_W-1:0];
                CFG_RANGE_SCALE: r_rs <= i_cfg_data[RS_W-1:0];
            endcase
        end
    end

    assign n_rc = (r_rs < RS_MIN) ? RS_MIN : ((r_rs > RS_MAX) ? RS_MAX : r_rs);

    always_ff @(posedge i_clk) begin
        r_d  <= D_W'(D_W'(FULL_SCALE_COUNTS) * D_W'(n_rc));
        r_dd <= DD_W'(r_d) * DD_W'(r_d);
        r_dv <= ONE_Q16 - Q_W'(r_dz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LEN-2:0], i_in_valid};
        end
    end

    // Magnitude and sign
    logic [MAG_W-1:0] n_mx;
    logic [MAG_W-1:0] n_my;
    t_sb              r_s1_sb;

    assign n_mx = i_in_data.x_raw[AXIS_W-1] ? (~$unsigned(i_in_data.x_raw) + 16'd1)
                                            : $unsigned(i_in_data.x_raw);
    assign n_my = i_in_data.y_raw[AXIS_W-1] ? (~$unsigned(i_in_data.y_raw) + 16'd1)
                                            : $unsigned(i_in_data.y_raw);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sb.mx    <= n_mx;
            r_s1_sb.my    <= n_my;
            r_s1_sb.nx    <= i_in_data.x_raw[AXIS_W-1];
            r_s1_sb.ny    <= i_in_data.y_raw[AXIS_W-1];
            r_s1_sb.kill  <= 1'b0;
            r_s1_sb.clamp <= 1'b0;
            r_s1_sb.s8    <= '0;
        end
    end

    // Squares
    logic [SQ_W-1:0] r_s2_sqx;
    logic [SQ_W-1:0] r_s2_sqy;
    t_sb             r_s2_sb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_sqx <= SQ_W'(r_s1_sb.mx) * SQ_W'(r_s1_sb.mx);
            r_s2_sqy <= SQ_W'(r_s1_sb.my) * SQ_W'(r_s1_sb.my);
            r_s2_sb  <= r_s1_sb;
        end
    end

    // Sum of squares
    logic [SQ_W-1:0] r_s3_p;
    t_sb             r_s3_sb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_p  <= r_s2_sqx + r_s2_sqy;
            r_s3_sb <= r_s2_sb;
        end
    end

    // Square root of P * 2^32, two radicand bits per stage
    logic [REM_W-1:0]  r_sq_rem  [0:SQ_STEPS];
    logic [ROOT_W-1:0] r_sq_root [0:SQ_STEPS];
    logic [SQ_W-1:0]   r_sq_rad  [0:SQ_STEPS];
    t_sb               r_sq_sb   [0:SQ_STEPS];
    t_sb               n_sq_sb;

    always_comb begin
        n_sq_sb       = r_s3_sb;
        n_sq_sb.kill  = (r_s3_p == '0);
        n_sq_sb.clamp = CMP_W'({r_s3_p, 16'h0000}) > CMP_W'(r_dd);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_rad[0]  <= r_s3_p;
            r_sq_sb[0]   <= n_sq_sb;
        end
    end

    for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sq
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        logic             ge;

        assign rem2  = {r_sq_rem[k-1][REM_W-3:0], r_sq_rad[k-1][SQ_W-1 -: 2]};
        assign trial = {r_sq_root[k-1], 2'b01};
        assign ge    = rem2 >= trial;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k]  <= ge ? (rem2 - trial) : rem2;
                r_sq_root[k] <= {r_sq_root[k-1][ROOT_W-2:0], ge};
                r_sq_rad[k]  <= {r_sq_rad[k-1][SQ_W-3:0], 2'b00};
                r_sq_sb[k]   <= r_sq_sb[k-1];
            end
        end
    end

    // Radius: S8 * 256 / D
    logic [D_W-1:0] r_d1_rem [0:R_STEPS];
    logic [Q_W-1:0] r_d1_q   [0:R_STEPS];
    logic [Q_W-1:0] r_d1_lo  [0:R_STEPS];
    t_sb            r_d1_sb  [0:R_STEPS];
    logic [ROOT_W-1:0] n_s8;
    t_sb            n_d1_sb;

    assign n_s8 = r_sq_root[SQ_STEPS];

    always_comb begin
        n_d1_sb    = r_sq_sb[SQ_STEPS];
        n_d1_sb.s8 = n_s8;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1_rem[0] <= D_W'(n_s8 >> 9);
            r_d1_q[0]   <= '0;
            r_d1_lo[0]  <= {n_s8[8:0], 8'h00};
            r_d1_sb[0]  <= n_d1_sb;
        end
    end

    for (genvar j = 1; j <= R_STEPS; j++) begin : g_d1
        logic [D_W:0] rem2;
        logic         ge;

        assign rem2 = {r_d1_rem[j-1], r_d1_lo[j-1][Q_W-1]};
        assign ge   = rem2 >= {1'b0, r_d};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d1_rem[j] <= D_W'(ge ? (rem2 - {1'b0, r_d}) : rem2);
                r_d1_q[j]   <= {r_d1_q[j-1][Q_W-2:0], ge};
                r_d1_lo[j]  <= {r_d1_lo[j-1][Q_W-2:0], 1'b0};
                r_d1_sb[j]  <= r_d1_sb[j-1];
            end
        end
    end

    // Clamp radius, deadzone test
    logic [Q_W-1:0] n_r16;
    logic [Q_W-1:0] r_r16;
    t_sb            r_r_sb;
    t_sb            n_r_sb;

    assign n_r16 = (r_d1_sb[R_STEPS].clamp || (r_d1_q[R_STEPS] > ONE_Q16))
                   ? ONE_Q16 : r_d1_q[R_STEPS];

    always_comb begin
        n_r_sb      = r_d1_sb[R_STEPS];
        n_r_sb.kill = r_d1_sb[R_STEPS].kill || (n_r16 <= Q_W'(r_dz));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r16  <= n_r16;
            r_r_sb <= n_r_sb;
        end
    end

    // Gain: (r16 - dz) * 65536 / (65536 - dz)
    logic [Q_W-1:0] r_g_rem [0:G_STEPS];
    logic [Q_W-1:0] r_g_q   [0:G_STEPS];
    logic [Q_W-1:0] r_g_lo  [0:G_STEPS];
    t_sb            r_g_sb  [0:G_STEPS];
    logic [Q_W-1:0] n_num;

    assign n_num = r_r16 - Q_W'(r_dz);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_rem[0] <= n_num >> 1;
            r_g_q[0]   <= '0;
            r_g_lo[0]  <= {n_num[0], 16'h0000};
            r_g_sb[0]  <= r_r_sb;
        end
    end

    for (genvar j = 1; j <= G_STEPS; j++) begin : g_gd
        logic [Q_W:0] rem2;
        logic         ge;

        assign rem2 = {r_g_rem[j-1], r_g_lo[j-1][Q_W-1]};
        assign ge   = rem2 >= {1'b0, r_dv};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_g_rem[j] <= Q_W'(ge ? (rem2 - {1'b0, r_dv}) : rem2);
                r_g_q[j]   <= {r_g_q[j-1][Q_W-2:0], ge};
                r_g_lo[j]  <= {r_g_lo[j-1][Q_W-2:0], 1'b0};
                r_g_sb[j]  <= r_g_sb[j-1];
            end
        end
    end

    // Gain times axis magnitude
    logic [P_W-1:0] r_m_px;
    logic [P_W-1:0] r_m_py;
    t_sb            r_m_sb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_px <= P_W'(r_g_q[G_STEPS]) * P_W'(r_g_sb[G_STEPS].mx);
            r_m_py <= P_W'(r_g_q[G_STEPS]) * P_W'(r_g_sb[G_STEPS].my);
            r_m_sb <= r_g_sb[G_STEPS];
        end
    end

    // Axis: round-half-up of g16 * a * 65536 / (2 * S8)
    logic [AR_W-1:0]   r_a_remx [0:A_STEPS];
    logic [AR_W-1:0]   r_a_remy [0:A_STEPS];
    logic [AXIS_W-1:0] r_a_qx   [0:A_STEPS];
    logic [AXIS_W-1:0] r_a_qy   [0:A_STEPS];
    logic [AXIS_W-1:0] r_a_lo   [0:A_STEPS];
    t_sb               r_a_sb   [0:A_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_remx[0] <= AR_W'(r_m_px + P_W'(r_m_sb.s8[ROOT_W-1:16]));
            r_a_remy[0] <= AR_W'(r_m_py + P_W'(r_m_sb.s8[ROOT_W-1:16]));
            r_a_qx[0]   <= '0;
            r_a_qy[0]   <= '0;
            r_a_lo[0]   <= r_m_sb.s8[15:0];
            r_a_sb[0]   <= r_m_sb;
        end
    end

    for (genvar j = 1; j <= A_STEPS; j++) begin : g_ax
        logic [AR_W:0] div2;
        logic [AR_W:0] rem2x;
        logic [AR_W:0] rem2y;
        logic          gex;
        logic          gey;

        assign div2  = {1'b0, r_a_sb[j-1].s8, 1'b0};
        assign rem2x = {r_a_remx[j-1], r_a_lo[j-1][AXIS_W-1]};
        assign rem2y = {r_a_remy[j-1], r_a_lo[j-1][AXIS_W-1]};
        assign gex   = rem2x >= div2;
        assign gey   = rem2y >= div2;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_a_remx[j] <= AR_W'(gex ? (rem2x - div2) : rem2x);
                r_a_remy[j] <= AR_W'(gey ? (rem2y - div2) : rem2y);
                r_a_qx[j]   <= {r_a_qx[j-1][AXIS_W-2:0], gex};
                r_a_qy[j]   <= {r_a_qy[j-1][AXIS_W-2:0], gey};
                r_a_lo[j]   <= {r_a_lo[j-1][AXIS_W-2:0], 1'b0};
                r_a_sb[j]   <= r_a_sb[j-1];
            end
        end
    end

    // Sign, saturate, output register
    logic [AXIS_W-1:0] n_ox;
    logic [AXIS_W-1:0] n_oy;
    t_out              r_out_data;
    logic              r_out_kill;

    always_comb begin
        if (r_a_sb[A_STEPS].kill) begin
            n_ox = '0;
        end else if (r_a_sb[A_STEPS].nx) begin
            n_ox = 16'h0000 - ((r_a_qx[A_STEPS] > NEG_MAX) ? NEG_MAX : r_a_qx[A_STEPS]);
        end else begin
            n_ox = (r_a_qx[A_STEPS] > POS_MAX) ? POS_MAX : r_a_qx[A_STEPS];
        end
        if (r_a_sb[A_STEPS].kill) begin
            n_oy = '0;
        end else if (r_a_sb[A_STEPS].ny) begin
            n_oy = 16'h0000 - ((r_a_qy[A_STEPS] > NEG_MAX) ? NEG_MAX : r_a_qy[A_STEPS]);
        end else begin
            n_oy = (r_a_qy[A_STEPS] > POS_MAX) ? POS_MAX : r_a_qy[A_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data.x_out <= $signed(n_ox);
            r_out_data.y_out <= $signed(n_oy);
            r_out_kill       <= r_a_sb[A_STEPS].kill;
        end
    end

    assign o_out_data = r_out_data;

    `include "assert_macros.svh"

    `ASD_ASSERT(a_stall_holds_valid, !en |=> $stable(r_vld), "valid bits moved during a stall")
    `ASD_ASSERT(a_accept_enters, (i_in_valid && en) |=> r_vld[0], "accepted request not in stage one")
    `ASD_ASSERT(a_kill_gives_zero, (o_out_valid && r_out_kill) |-> (o_out_data == '0), "deadzone result not zero")

endmodule

### bench/asd_scoreboard.sv
// Scoreboard for the radial deadzone core: tracks registers, predicts each result and compares.
module asd_scoreboard
    import asd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in                   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out                  i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_cnt,
    output int                    o_pending_cnt
);

    localparam longint unsigned FULL_COUNTS = FULL_SCALE_COUNTS_DEF;

    logic [DZ_W-1:0] dz_reg = DZ_RESET;
    logic [RS_W-1:0] rs_reg = RS_RESET;
    t_out            stick_q[$];

    assign o_pending_cnt = stick_q.size();

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [AXIS_W-1:0] scale_axis(longint unsigned gain, longint unsigned mag,
                                                     longint unsigned root, logic neg);
        longint unsigned m;
        m = (gain * mag * 256 + root) / (2 * root);
        if (neg) begin
            if (m > 32768) m = 32768;
            return AXIS_W'(65536 - m);
        end
        if (m > 32767) m = 32767;
        return AXIS_W'(m);
    endfunction

    function automatic t_out condition_stick(t_in req);
        t_out            res;
        longint unsigned ax, ay, rc, d, q, root, r16, dz, gain;
        logic            nx, ny;
        nx  = req.x_raw[AXIS_W-1];
        ny  = req.y_raw[AXIS_W-1];
        ax  = (nx ? 65536 - longint'(unsigned'(req.x_raw)) : longint'(unsigned'(req.x_raw))) * 256;
        ay  = (ny ? 65536 - longint'(unsigned'(req.y_raw)) : longint'(unsigned'(req.y_raw))) * 256;
        res = '0;
        rc  = rs_reg;
        if (rc < RS_MIN) rc = RS_MIN;
        if (rc > RS_MAX) rc = RS_MAX;
        d = FULL_COUNTS * rc;
        q = ax * ax + ay * ay;
        if (q == 0) return res;
        root = int_sqrt(q << 16);
        if (q > d * d) begin
            r16 = 65536;
        end else begin
            r16 = (root * 256) / d;
            if (r16 > 65536) r16 = 65536;
        end
        dz = dz_reg;
        if (r16 <= dz) return res;
        gain = ((r16 - dz) * 65536) / (65536 - dz);
        res.x_out = scale_axis(gain, ax, root, nx);
        res.y_out = scale_axis(gain, ay, root, ny);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [AXIS_W-1:0] got, logic [AXIS_W-1:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t",
                 what, $signed(got), $signed(want), $realtime);
        o_fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            dz_reg = DZ_RESET;
            rs_reg = RS_RESET;
            stick_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (stick_q.size() == 0) begin
                    report_mismatch("unexpected result x", i_out_data.x_out, '0);
                end else begin
                    want = stick_q.pop_front();
                    if (i_out_data.x_out !== want.x_out)
                        report_mismatch("x_out", i_out_data.x_out, want.x_out);
                    if (i_out_data.y_out !== want.y_out)
                        report_mismatch("y_out", i_out_data.y_out, want.y_out);
                end
            end
            if (i_in_valid && i_in_ready)
                stick_q.push_back(condition_stick(i_in_data));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_DEAD_ZONE)
                    dz_reg = i_cfg_data[DZ_W-1:0];
                else if (i_cfg_index == CFG_RANGE_SCALE)
                    rs_reg = i_cfg_data[RS_W-1:0];
            end
        end
    end

endmodule

### bench/tb_analog_stick_radial_deadzone_core.sv
// Top of the radial deadzone core bench: stimulus, flow control, watchdog and verdict.
module tb_analog_stick_radial_deadzone_core;
    import asd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 120;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    t_in                   in_data    = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    t_out                  out_data;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    int                    fail_cnt;
    int                    pending_cnt;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_ask       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int cycle_cnt      = 0;
    int rs_now         = RS_RESET;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    analog_stick_radial_deadzone_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    asd_scoreboard u_scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_cnt    (fail_cnt),
        .o_pending_cnt (pending_cnt)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // hold off the result side for a long stretch on request
    always @(posedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= 300;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_stick(logic signed [AXIS_W-1:0] x, logic signed [AXIS_W-1:0] y);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        in_data.x_raw <= x;
        in_data.y_raw <= y;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_RANGE_SCALE) begin
            rs_now = val[RS_W-1:0];
            if (rs_now < RS_MIN) rs_now = RS_MIN;
            if (rs_now > RS_MAX) rs_now = RS_MAX;
        end
    endtask

    task automatic reconfigure(logic [CFG_DATA_W-1:0] dz, logic [CFG_DATA_W-1:0] rs);
        settle();
        write_reg(CFG_DEAD_ZONE, dz);
        write_reg(CFG_RANGE_SCALE, rs);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_sticks(int count);
        int lim;
        for (int k = 0; k < count; k++) begin
            lim = (130 * rs_now) / 256;
            if ($urandom_range(0, 3) == 0)
                send_stick(AXIS_W'($urandom), AXIS_W'($urandom));
            else
                send_stick(AXIS_W'($urandom_range(0, 2 * lim) - lim),
                           AXIS_W'($urandom_range(0, 2 * lim) - lim));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        send_stick(0, 0);
        send_stick(32767, 0);
        send_stick(-32768, 0);
        send_stick(0, 32767);
        send_stick(0, -32768);
        send_stick(-32768, -32768);
        send_stick(32767, 32767);
        send_stick(100, 0);
        send_stick(-100, 0);
        send_stick(0, 100);
        send_stick(70, 70);
        send_stick(1, 0);
        send_stick(-1, 1);
        send_stick(50, -20);
        reconfigure(16'd16384, 16'd384);
        send_stick(10, 10);
        send_stick(120, -60);
        send_stick(-300, 5);
        reconfigure(16'hFFFF, 16'd0);
        send_stick(100, 0);
        send_stick(32767, -32768);
        reconfigure(16'd0, 16'h01FF);
        send_stick(-32768, 0);
        send_stick(200, 200);

        reconfigure(16'd0, 16'd256);
        hold_ask++;
        random_sticks(220);

        reconfigure(AXIS_W'($urandom_range(0, 40000)), 16'd128);
        send_idle_pct = 53;
        random_sticks(200);

        reconfigure(16'd8192, 16'd384);
        send_idle_pct  = 0;
        recv_stall_pct = 53;
        random_sticks(200);

        reconfigure(16'd20000, 16'd60);
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        random_sticks(200);

        settle();
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
